/* rtl/core/nts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg
// shared field widths, command codes and the result bundle of the lookup
// ----------------------------------------------------------------------------
package nts_pkg;

	localparam int unsigned TIME_W = 63;
	localparam int unsigned AGE_W  = 6;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} nts_cmd_t;

	typedef struct packed {
		logic              found;
		logic [AGE_W-1:0]  entry_age;
		logic [TIME_W-1:0] match_time;
	} nts_result_t;

endpackage
`default_nettype wire

/* rtl/core/nts_stamp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nts_stamp_ram
// timestamp store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module nts_stamp_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 63
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/nts_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nts_search
// binary search sequencer: narrows [lo, hi] by midpoint reads, then picks
// the closer of the final pair, holding the result until it is taken
// ----------------------------------------------------------------------------
module nts_search #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [nts_pkg::TIME_W-1:0]        query_time,
	input  wire logic [$clog2(RING_DEPTH)-1:0]     oldest,
	input  wire logic [$clog2(RING_DEPTH):0]       count,
	output logic                                   rd_en,
	output logic      [$clog2(RING_DEPTH)-1:0]     rd_addr,
	input  wire logic [nts_pkg::TIME_W-1:0]        rd_data,
	output logic                                   res_valid,
	output nts_pkg::nts_result_t                   res,
	input  wire logic                              res_take
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH_V = (AW+1)'(RING_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STEP,
		S_MCMP,
		S_SINGLE,
		S_PLO,
		S_PHI,
		S_OUT
	} state_t;

	state_t                      state_q;
	logic [AW-1:0]               lo_q;
	logic [AW-1:0]               hi_q;
	logic [AW-1:0]               mid_q;
	logic [nts_pkg::TIME_W-1:0]  t_q;
	logic [nts_pkg::TIME_W-1:0]  dl_q;
	logic [nts_pkg::TIME_W-1:0]  lo_stamp_q;
	nts_pkg::nts_result_t        res_q;

	logic [AW-1:0]               span;
	logic [AW-1:0]               mid;
	logic                        is_single;
	logic                        is_pair;
	logic [AW-1:0]               rd_age;
	logic [AW:0]                 slot_sum;
	logic [nts_pkg::TIME_W-1:0]  dr;
	logic [AW+5:0]               lo_wide;
	logic [AW+5:0]               hi_wide;

	assign span      = hi_q - lo_q;
	assign mid       = lo_q + (span >> 1);
	assign is_single = (span == '0);
	assign is_pair   = (span == AW'(1));
	assign lo_wide   = {6'd0, lo_q};
	assign hi_wide   = {6'd0, hi_q};

	// age to ring slot, wrapping past the end of the store
	always_comb begin
		if (state_q == S_PLO) begin
			rd_age = hi_q;
		end else if (is_single || is_pair) begin
			rd_age = lo_q;
		end else begin
			rd_age = mid;
		end
		slot_sum = {1'b0, oldest} + {1'b0, rd_age};
		if (slot_sum >= DEPTH_V) begin
			slot_sum = slot_sum - DEPTH_V;
		end
		rd_addr = slot_sum[AW-1:0];
	end

	assign rd_en     = (state_q == S_STEP) || (state_q == S_PLO);
	assign dr        = (t_q >= rd_data) ? (t_q - rd_data) : (rd_data - t_q);
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			t_q        <= '0;
			dl_q       <= '0;
			lo_stamp_q <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						lo_q <= '0;
						hi_q <= AW'(count - (AW+1)'(1));
						t_q  <= query_time;
						if (count == '0) begin
							res_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				S_STEP: begin
					mid_q <= mid;
					priority if (is_single) begin
						state_q <= S_SINGLE;
					end else if (is_pair) begin
						state_q <= S_PLO;
					end else begin
						state_q <= S_MCMP;
					end
				end
				S_MCMP: begin
					if (rd_data < t_q) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_STEP;
				end
				S_SINGLE: begin
					res_q.found      <= 1'b1;
					res_q.entry_age  <= lo_wide[5:0];
					res_q.match_time <= rd_data;
					state_q          <= S_OUT;
				end
				S_PLO: begin
					dl_q       <= dr;
					lo_stamp_q <= rd_data;
					state_q    <= S_PHI;
				end
				S_PHI: begin
					// tie goes to the newer entry
					res_q.found <= 1'b1;
					if (dl_q < dr) begin
						res_q.entry_age  <= lo_wide[5:0];
						res_q.match_time <= lo_stamp_q;
					end else begin
						res_q.entry_age  <= hi_wide[5:0];
						res_q.match_time <= rd_data;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/nearest_timestamp_lookup.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_timestamp_lookup
// ring of timestamps with a nearest-time binary search query
// ----------------------------------------------------------------------------
// An insert item (cmd=0) appends time_usec to a ring of RING_DEPTH entries,
// overwriting the oldest once the ring is full, and gives no result. A query
// item (cmd=1) gives one result: the held entry nearest to time_usec (ties go
// to the newer one), its age (0 is the oldest held) and its timestamp, or
// found=0 with zero fields on an empty ring. The search reads the stamp
// memory once per halving, each step giving the address and then comparing
// on the registered read data, and ends with two reads for the final pair
// or one read for a lone entry. A finished result waits in the search while
// the previous result still waits in the output register. One query is in
// flight at a time; inserts and the next query are accepted while a result
// waits in the output register.
// ----------------------------------------------------------------------------
module nearest_timestamp_lookup #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input item channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           cmd,
	input  wire logic [nts_pkg::TIME_W-1:0]     time_usec,
	// result item channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                found,
	output logic      [nts_pkg::AGE_W-1:0]      entry_age,
	output logic      [nts_pkg::TIME_W-1:0]     match_time
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH_V = (AW+1)'(RING_DEPTH);

	// ring bookkeeping
	logic [AW-1:0]               oldest_q;
	logic [AW:0]                 count_q;
	logic                        busy_q;

	// output register
	logic                        out_valid_q;
	nts_pkg::nts_result_t        out_q;

	logic                        in_fire;
	logic                        ins_fire;
	logic                        qry_fire;
	logic                        full;
	logic [AW:0]                 wr_sum;
	logic [AW-1:0]               wr_addr;

	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [nts_pkg::TIME_W-1:0]  rd_data;
	logic                        res_valid;
	nts_pkg::nts_result_t        res;
	logic                        take;

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;
	assign ins_fire = in_fire && (cmd == nts_pkg::CMD_INSERT);
	assign qry_fire = in_fire && (cmd == nts_pkg::CMD_QUERY);
	assign full     = (count_q == DEPTH_V);

	// the output register frees when empty or being drained this cycle
	assign take = !out_valid_q || out_ready;

	// append slot: one past the newest, or the oldest once full
	always_comb begin
		wr_sum = {1'b0, oldest_q} + {1'b0, count_q[AW-1:0]};
		if (wr_sum >= DEPTH_V) begin
			wr_sum = wr_sum - DEPTH_V;
		end
		wr_addr = full ? oldest_q : wr_sum[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_fire) begin
				if (full) begin
					// overwrite the oldest and move the ring start
					oldest_q <= (oldest_q == AW'(RING_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
				end else begin
					count_q <= count_q + (AW+1)'(1);
				end
			end
			// a query holds the input side until its result is handed over
			if (qry_fire) begin
				busy_q <= 1'b1;
			end else if (res_valid && take) begin
				busy_q <= 1'b0;
			end
			if (res_valid && take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid && take) begin
			out_q <= res;
		end
	end

	nts_stamp_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (nts_pkg::TIME_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ins_fire),
		.wr_addr (wr_addr),
		.wr_data (time_usec),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	nts_search #(
		.RING_DEPTH (RING_DEPTH)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (qry_fire),
		.query_time (time_usec),
		.oldest     (oldest_q),
		.count      (count_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (take)
	);

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign entry_age  = out_q.entry_age;
	assign match_time = out_q.match_time;

endmodule
`default_nettype wire

/* rtl/core/nts_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nts_checker
// port-level checks of the lookup, bound to the top level
// ----------------------------------------------------------------------------
module nts_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        cmd,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        found,
	input wire logic [nts_pkg::AGE_W-1:0]   entry_age,
	input wire logic [nts_pkg::TIME_W-1:0]  match_time
);

	logic [1:0] pending_q;
	logic       qry_fire;
	logic       out_fire;

	assign qry_fire = in_valid && in_ready && (cmd == nts_pkg::CMD_QUERY);
	assign out_fire = out_valid && out_ready;

	// queries accepted whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(qry_fire) - 2'(out_fire);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(entry_age)
			&& $stable(match_time))
		else $error("result item changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> entry_age == '0 && match_time == '0)
		else $error("empty-ring result carries nonzero fields");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result item without a pending query");

	a_one_query: assert property (@(posedge clk) disable iff (!arst_n)
		qry_fire |=> !in_ready)
		else $error("input taken while a query is in flight");

	a_ready_back: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pending_q != '0)
		else $error("input stalled with no query in flight");

endmodule

bind nearest_timestamp_lookup nts_checker u_nts_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for nearest_timestamp_lookup
// ----------------------------------------------------------------------------
// A short directed table runs first: the empty ring, a lone entry, ties,
// the time extremes, timestamps that go backwards and a ring that wraps.
// Random streams follow. They are mostly increasing timestamps, with queries
// aimed at held entries, at the points halfway between neighbors and at the
// ends of the ring, plus some stray values. A local model of the ring predicts
// every query answer that the table does not fix, and each answer is checked
// in order, one field at a time. The run goes through several sender and
// receiver idling mixes and one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TIME_W = nts_pkg::TIME_W;
	localparam int unsigned AGE_W = nts_pkg::AGE_W;

	localparam int unsigned RING_DEPTH = 64;
	// wait after the last answer so that the block settles
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 330;
	localparam int unsigned PRESSURE_ITEMS = 60;
	localparam int unsigned PRESSURE_HOLD = 400;
	localparam int unsigned REPORT_CAP = 40;
	// idling mixes in percent: none, sender only, receiver only, both
	localparam int unsigned SEND_IDLE_PCT [4] = '{0, 71, 0, 35};
	localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 71, 35};

	localparam logic [TIME_W-1:0] T_MAX = '1;
	localparam logic [TIME_W-1:0] ALT_A = 63'h2AAA_AAAA_AAAA_AAAA;
	localparam logic [TIME_W-1:0] ALT_B = 63'h5555_5555_5555_5555;
	localparam nts_pkg::nts_result_t EMPTY_ANSWER = '0;

	// one row of the directed table, an insert row repeats with a stride
	typedef struct {
		nts_pkg::nts_cmd_t    op;
		logic [TIME_W-1:0]    t;
		int unsigned          reps;
		logic [TIME_W-1:0]    stride;
		bit                   typed;
		nts_pkg::nts_result_t want;
	} stim_row_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              cmd = 1'b0;
	logic [TIME_W-1:0] time_usec = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              found;
	logic [AGE_W-1:0]  entry_age;
	logic [TIME_W-1:0] match_time;

	// answers predicted for accepted queries, oldest first
	nts_pkg::nts_result_t pending_answers [$];
	stim_row_t            directed_rows [$];

	// local copy of the ring
	logic [TIME_W-1:0] ring_stamp [RING_DEPTH];
	int unsigned       ring_head = 0;
	int unsigned       ring_fill = 0;

	// typed answer that goes with the item on the port, if any
	bit                   row_typed = 1'b0;
	nts_pkg::nts_result_t row_answer = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	// last timestamp of the increasing stream
	logic [TIME_W-1:0] stream_time = '0;

	nearest_timestamp_lookup #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.time_usec (time_usec),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.entry_age (entry_age),
		.match_time(match_time)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// ring model
	// ------------------------------------------------------------------

	function automatic logic [TIME_W-1:0] held_stamp(input int unsigned age);
		return ring_stamp[(ring_head + age) % RING_DEPTH];
	endfunction

	function automatic void ring_insert(input logic [TIME_W-1:0] t);
		if (ring_fill < RING_DEPTH) begin
			ring_stamp[(ring_head + ring_fill) % RING_DEPTH] = t;
			ring_fill++;
		end else begin
			// full: the oldest slot takes the new stamp and the head moves on
			ring_stamp[ring_head] = t;
			ring_head = (ring_head + 1) % RING_DEPTH;
		end
	endfunction

	function automatic logic [TIME_W-1:0] stamp_gap(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// binary search down to two neighbors, then the closer one, newer on a tie
	function automatic nts_pkg::nts_result_t nearest_lookup(input logic [TIME_W-1:0] t);
		nts_pkg::nts_result_t res;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		int unsigned pick;
		res = EMPTY_ANSWER;
		if (ring_fill == 0)
			return res;
		lo = 0;
		hi = ring_fill - 1;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			if (held_stamp(mid) < t)
				lo = mid;
			else
				hi = mid;
		end
		if (lo == hi)
			pick = lo;
		else
			pick = (stamp_gap(t, held_stamp(lo)) < stamp_gap(t, held_stamp(hi))) ? lo : hi;
		res.found = 1'b1;
		res.entry_age = pick[AGE_W-1:0];
		res.match_time = held_stamp(pick);
		return res;
	endfunction

	function automatic nts_pkg::nts_result_t hit(input int unsigned age,
			input logic [TIME_W-1:0] t);
		nts_pkg::nts_result_t res;
		res.found = 1'b1;
		res.entry_age = age[AGE_W-1:0];
		res.match_time = t;
		return res;
	endfunction

	function automatic logic [TIME_W-1:0] any_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	// small offset of either sign, wraps like the 63-bit field does
	function automatic logic [TIME_W-1:0] jitter(input logic [TIME_W-1:0] t);
		return t + TIME_W'($urandom_range(40)) - TIME_W'(20);
	endfunction

	// next random item: mostly an increasing stream, queries aimed at it
	function automatic void draw_item(input int unsigned query_pct,
			output nts_pkg::nts_cmd_t op, output logic [TIME_W-1:0] t);
		int unsigned r;
		int unsigned age;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		r = $urandom_range(99);
		if (ring_fill == 0 || $urandom_range(99) >= query_pct) begin
			op = nts_pkg::CMD_INSERT;
			if (r < 3) begin
				// restart the stream anywhere, high bits included
				stream_time = any_stamp();
				t = stream_time;
			end else if (r < 8) begin
				// stray value, stream left alone
				t = any_stamp();
			end else if (r < 13) begin
				// repeated stamp, equal neighbors
				t = stream_time;
			end else if (r < 18) begin
				stream_time = stream_time + TIME_W'({$urandom_range(255), $urandom});
				t = stream_time;
			end else begin
				stream_time = stream_time + TIME_W'($urandom_range(1, 3000));
				t = stream_time;
			end
		end else begin
			op = nts_pkg::CMD_QUERY;
			age = $urandom_range(ring_fill - 1);
			if (r < 35) begin
				t = jitter(held_stamp(age));
			end else if (r < 60 && ring_fill > 1) begin
				// halfway between neighbors, an exact tie when the gap is even
				if (age == ring_fill - 1)
					age--;
				a = held_stamp(age);
				b = held_stamp(age + 1);
				t = (b >= a) ? a + (b - a) / 2 : b + (a - b) / 2;
				if ($urandom_range(1))
					t = jitter(t);
			end else if (r < 70) begin
				t = held_stamp(0) - TIME_W'($urandom_range(500));
			end else if (r < 80) begin
				t = held_stamp(ring_fill - 1) + TIME_W'($urandom_range(500));
			end else if (r < 88) begin
				t = $urandom_range(1) ? T_MAX : '0;
			end else begin
				t = any_stamp();
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// results are checked before new items are modeled, so an answer can
	// never be taken for the query accepted at the same edge
	always @(posedge clk) begin : port_watch
		nts_pkg::nts_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_answers.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected, match_time %0h",
						match_time));
				end else begin
					want = pending_answers.pop_front();
					if (found !== want.found)
						flag_mismatch($sformatf("found expected %0b got %0b",
							want.found, found));
					if (entry_age !== want.entry_age)
						flag_mismatch($sformatf("entry_age expected %0d got %0d",
							want.entry_age, entry_age));
					if (match_time !== want.match_time)
						flag_mismatch($sformatf("match_time expected %0h got %0h",
							want.match_time, match_time));
				end
			end
			if (in_valid && in_ready) begin
				if (cmd == nts_pkg::CMD_INSERT) begin
					ring_insert(time_usec);
				end else begin
					want = row_typed ? row_answer : nearest_lookup(time_usec);
					pending_answers.push_back(want);
				end
			end
		end
	end

	// receiver: a long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// present one item, idling first as the current mix asks, and return at
	// the edge that takes it
	task automatic offer(input nts_pkg::nts_cmd_t op, input logic [TIME_W-1:0] t,
			input bit typed, input nts_pkg::nts_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		time_usec = t;
		row_typed = typed;
		row_answer = want;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// sender stands down until every answer is in, then lets the block settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input nts_pkg::nts_cmd_t op, input logic [TIME_W-1:0] t,
			input int unsigned reps, input logic [TIME_W-1:0] stride,
			input bit typed, input nts_pkg::nts_result_t want);
		stim_row_t row;
		row.op = op;
		row.t = t;
		row.reps = reps;
		row.stride = stride;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	initial begin : stimulus
		nts_pkg::nts_cmd_t op;
		logic [TIME_W-1:0] t;

		// empty ring at both time extremes
		add_row(nts_pkg::CMD_QUERY,  '0,    1, '0, 1'b1, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  T_MAX, 1, '0, 1'b1, EMPTY_ANSWER);
		// lone entry comes back whatever the time
		add_row(nts_pkg::CMD_INSERT, 1000,  1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  '0,    1, '0, 1'b1, hit(0, 1000));
		add_row(nts_pkg::CMD_QUERY,  T_MAX, 1, '0, 1'b1, hit(0, 1000));
		// two entries: exact tie goes to the newer one
		add_row(nts_pkg::CMD_INSERT, 2000,  1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  1500,  1, '0, 1'b1, hit(1, 2000));
		add_row(nts_pkg::CMD_QUERY,  1499,  1, '0, 1'b1, hit(0, 1000));
		// largest timestamp held
		add_row(nts_pkg::CMD_INSERT, T_MAX, 1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  T_MAX, 1, '0, 1'b1, hit(2, T_MAX));
		add_row(nts_pkg::CMD_QUERY,  '0,    1, '0, 1'b1, hit(0, 1000));
		// timestamps going backwards, alternating bit patterns
		add_row(nts_pkg::CMD_INSERT, '0,    1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  1000,  1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_INSERT, ALT_A, 1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  ALT_B, 1, '0, 1'b0, EMPTY_ANSWER);
		// fill past the depth so the oldest entries are overwritten
		add_row(nts_pkg::CMD_INSERT, 5000, RING_DEPTH + 2, 1000, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  '0,    1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  T_MAX, 1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  45500, 1, '0, 1'b0, EMPTY_ANSWER);
		// backwards stamp into a full ring
		add_row(nts_pkg::CMD_INSERT, 7,     1, '0, 1'b0, EMPTY_ANSWER);
		add_row(nts_pkg::CMD_QUERY,  7,     1, '0, 1'b0, EMPTY_ANSWER);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			for (int unsigned k = 0; k < directed_rows[i].reps; k++) begin
				t = directed_rows[i].t + TIME_W'(k) * directed_rows[i].stride;
				offer(directed_rows[i].op, t, directed_rows[i].typed, directed_rows[i].want);
			end
		wait_drained();

		// random streams under each idling mix
		stream_time = TIME_W'($urandom_range(100000));
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE_PCT[p];
			recv_stall_pct = RECV_STALL_PCT[p];
			repeat (PHASE_ITEMS) begin
				draw_item(60, op, t);
				offer(op, t, 1'b0, EMPTY_ANSWER);
			end
			wait_drained();
		end

		// receiver holds off while queries keep coming, the block backs up
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = PRESSURE_HOLD;
		repeat (PRESSURE_ITEMS) begin
			draw_item(85, op, t);
			offer(op, t, 1'b0, EMPTY_ANSWER);
		end
		wait_drained();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
